// File: src/vwd_pkg.sv
// Shared types and constants for the vertex welder.
// Used by vwd_near and vertex_weld_dedup; depends on nothing.
`default_nettype none

package vwd_pkg;

    // Table geometry
    localparam int MAX_VERTS  = 1024;
    localparam int IDX_W      = $clog2(MAX_VERTS);
    localparam int CNT_W      = IDX_W + 1;

    // Coordinates: signed fixed point, six fraction bits
    localparam int COORD_BITS = 24;
    localparam int POS_W      = 3 * COORD_BITS;

    // Weld tolerance register
    localparam int EPS_W                = 16;
    localparam logic [EPS_W-1:0] EPS_RST = 16'd16;

    // Item kinds
    typedef enum logic [1:0] {
        KIND_VERTEX   = 2'd0,
        KIND_TRIANGLE = 2'd1,
        KIND_START    = 2'd2,
        KIND_UNUSED   = 2'd3
    } t_kind;

    typedef logic signed [COORD_BITS-1:0] t_coord;

    typedef struct packed {
        t_coord x;
        t_coord y;
        t_coord z;
    } t_pos;

endpackage

`default_nettype wire

// File: src/vwd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module vwd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: src/vwd_near.sv
// Shared proximity compare: one stored position against the probe, per axis.
// Depends on vwd_pkg.
`default_nettype none

module vwd_near (
    input  wire vwd_pkg::t_pos                 i_probe,
    input  wire vwd_pkg::t_pos                 i_entry,
    input  wire logic [vwd_pkg::EPS_W-1:0]     i_eps,
    output      logic                          o_near
);

    localparam int DW = vwd_pkg::COORD_BITS + 1;

    // |a - b| < eps, with one guard bit so the difference never wraps
    function automatic logic axis_near(input vwd_pkg::t_coord a,
                                       input vwd_pkg::t_coord b,
                                       input logic [vwd_pkg::EPS_W-1:0] eps);
        logic signed [DW-1:0] d;
        logic [DW-1:0]        ad;
        logic [DW-1:0]        e;
        d  = DW'(a) - DW'(b);
        ad = d[DW-1] ? DW'(-d) : DW'(d);
        e  = DW'(eps);
        return ad < e;
    endfunction

    assign o_near = axis_near(i_probe.x, i_entry.x, i_eps)
                  & axis_near(i_probe.y, i_entry.y, i_eps)
                  & axis_near(i_probe.z, i_entry.z, i_eps);

endmodule

`default_nettype wire

// File: src/vertex_weld_dedup.sv
// Vertex welder top level: sequencer, counters, position and remap memories.
// Depends on vwd_pkg, vwd_ram and vwd_near.
`default_nettype none

// Usage
//   An item transfers on a rising edge with i_start high and o_busy low.
//   i_kind selects vertex, triangle or start-of-mesh; the other fields are
//   used only by the kind that needs them. Each item yields one result,
//   shown for exactly one cycle with o_done high; the receiver cannot stall.
//   Timing
//   Start, unused kind and a vertex that finds the remap table full:
//   result in the cycle after the transfer, o_busy stays low.
//   Vertex: the stored unique positions are scanned one per cycle through
//   the shared compare unit, fed by the position memory read port. A match
//   at entry k ends the scan and registers its result; a miss over n entries
//   appends in S_APPEND (an empty table goes there straight from the
//   transfer). The longest case is a miss over 1023 stored entries.
//   Triangle: three reads of the remap memory, result once the third returns.
//   The next item may transfer in the cycle its result is shown.
//   Reset
//   i_rst_n low clears both counts and sets the tolerance to 0.25 (16).
//   Memory contents are not cleared; only entries below the counts are used.
//   i_cfg_we writes the tolerance; write it only while the block is idle.
module vertex_weld_dedup (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_start,
    output      logic                              o_busy,
    input  wire logic [1:0]                        i_kind,
    input  wire logic signed [23:0]                i_pos_x,
    input  wire logic signed [23:0]                i_pos_y,
    input  wire logic signed [23:0]                i_pos_z,
    input  wire logic [9:0]                        i_corner_a,
    input  wire logic [9:0]                        i_corner_b,
    input  wire logic [9:0]                        i_corner_c,
    input  wire logic                              i_cfg_we,
    input  wire logic [vwd_pkg::EPS_W-1:0]         i_cfg_wdata,
    output      logic                              o_done,
    output      logic [9:0]                        o_unique_index,
    output      logic                              o_is_new,
    output      logic                              o_overflow,
    output      logic [9:0]                        o_out_a,
    output      logic [9:0]                        o_out_b,
    output      logic [9:0]                        o_out_c,
    output      logic                              o_keep
);

    localparam int IW = vwd_pkg::IDX_W;
    localparam int CW = vwd_pkg::CNT_W;
    localparam logic [CW-1:0] MAXC = CW'(vwd_pkg::MAX_VERTS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_APPEND,
        S_TRI
    } t_state;

    t_state                    r_state;
    logic [vwd_pkg::EPS_W-1:0] r_eps;
    logic [CW-1:0]             r_ucnt;
    logic [CW-1:0]             r_acnt;
    logic [IW-1:0]             r_cmp_idx;
    vwd_pkg::t_pos             r_pos;
    logic [IW-1:0]             r_cb;
    logic [IW-1:0]             r_cc;
    logic [1:0]                r_step;
    logic [IW-1:0]             r_ra;
    logic [IW-1:0]             r_rb;

    vwd_pkg::t_pos             n_probe;
    vwd_pkg::t_pos             pos_rdata;
    logic [vwd_pkg::POS_W-1:0] pos_rdata_raw;
    logic [IW-1:0]             pos_raddr;
    logic                      pos_we;
    logic [IW-1:0]             remap_raddr;
    logic [IW-1:0]             remap_rdata;
    logic                      remap_we;
    logic [IW-1:0]             remap_wdata;
    logic                      hit;
    logic                      last;
    logic                      room;
    logic [IW-1:0]             cur_corner;
    logic [IW-1:0]             corner_val;

    assign o_busy = (r_state != S_IDLE);

    // Probe from the ports, low COORD_BITS of each field
    assign n_probe.x = i_pos_x[vwd_pkg::COORD_BITS-1:0];
    assign n_probe.y = i_pos_y[vwd_pkg::COORD_BITS-1:0];
    assign n_probe.z = i_pos_z[vwd_pkg::COORD_BITS-1:0];

    assign pos_rdata = vwd_pkg::t_pos'(pos_rdata_raw);

    // Scan status
    assign last = ({1'b0, r_cmp_idx} == (r_ucnt - CW'(1)));
    assign room = (r_ucnt < MAXC);

    // Read addresses: entry 0 on transfer, then the next entry each cycle
    assign pos_raddr = (r_state == S_SCAN) ? IW'(r_cmp_idx + IW'(1)) : '0;

    always_comb begin
        case (r_step)
            2'd0:    remap_raddr = r_cb;
            2'd1:    remap_raddr = r_cc;
            default: remap_raddr = r_cc;
        endcase
        if (r_state == S_IDLE) begin
            remap_raddr = i_corner_a;
        end
    end

    // Remap lookup of the corner whose data is on the read port
    always_comb begin
        case (r_step)
            2'd0:    cur_corner = r_ra;
            2'd1:    cur_corner = r_cb;
            default: cur_corner = r_cc;
        endcase
        corner_val = ({1'b0, cur_corner} < r_acnt) ? remap_rdata : '0;
    end

    // Memory writes
    assign pos_we      = (r_state == S_APPEND) && room;
    assign remap_we    = ((r_state == S_SCAN) && hit) || pos_we;
    assign remap_wdata = (r_state == S_SCAN) ? r_cmp_idx : r_ucnt[IW-1:0];

    vwd_ram #(
        .WIDTH (vwd_pkg::POS_W),
        .DEPTH (vwd_pkg::MAX_VERTS)
    ) u_pos_ram (
        .i_clk   (i_clk),
        .i_we    (pos_we),
        .i_waddr (r_ucnt[IW-1:0]),
        .i_wdata (r_pos),
        .i_raddr (pos_raddr),
        .o_rdata (pos_rdata_raw)
    );

    vwd_ram #(
        .WIDTH (IW),
        .DEPTH (vwd_pkg::MAX_VERTS)
    ) u_remap_ram (
        .i_clk   (i_clk),
        .i_we    (remap_we),
        .i_waddr (r_acnt[IW-1:0]),
        .i_wdata (remap_wdata),
        .i_raddr (remap_raddr),
        .o_rdata (remap_rdata)
    );

    vwd_near u_near (
        .i_probe (r_pos),
        .i_entry (pos_rdata),
        .i_eps   (r_eps),
        .o_near  (hit)
    );

    // Sequencer, counters and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_eps          <= vwd_pkg::EPS_RST;
            r_ucnt         <= '0;
            r_acnt         <= '0;
            o_done         <= 1'b0;
            o_unique_index <= '0;
            o_is_new       <= 1'b0;
            o_overflow     <= 1'b0;
            o_out_a        <= '0;
            o_out_b        <= '0;
            o_out_c        <= '0;
            o_keep         <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_eps <= i_cfg_wdata;
            end
            o_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_pos          <= n_probe;
                        r_ra           <= i_corner_a;
                        r_cb           <= i_corner_b;
                        r_cc           <= i_corner_c;
                        r_step         <= 2'd0;
                        r_cmp_idx      <= '0;
                        o_unique_index <= '0;
                        o_is_new       <= 1'b0;
                        o_overflow     <= 1'b0;
                        o_out_a        <= '0;
                        o_out_b        <= '0;
                        o_out_c        <= '0;
                        o_keep         <= 1'b0;
                        case (vwd_pkg::t_kind'(i_kind))
                            vwd_pkg::KIND_VERTEX: begin
                                if (r_acnt >= MAXC) begin
                                    o_overflow <= 1'b1;
                                    o_done     <= 1'b1;
                                end else if (r_ucnt == '0) begin
                                    r_state <= S_APPEND;
                                end else begin
                                    r_state <= S_SCAN;
                                end
                            end
                            vwd_pkg::KIND_TRIANGLE: begin
                                r_state <= S_TRI;
                            end
                            vwd_pkg::KIND_START: begin
                                r_ucnt <= '0;
                                r_acnt <= '0;
                                o_done <= 1'b1;
                            end
                            default: begin
                                o_done <= 1'b1;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    if (hit) begin
                        r_acnt         <= r_acnt + CW'(1);
                        o_unique_index <= r_cmp_idx;
                        o_done         <= 1'b1;
                        r_state        <= S_IDLE;
                    end else if (last) begin
                        r_state <= S_APPEND;
                    end else begin
                        r_cmp_idx <= r_cmp_idx + IW'(1);
                    end
                end
                S_APPEND: begin
                    if (room) begin
                        r_ucnt         <= r_ucnt + CW'(1);
                        r_acnt         <= r_acnt + CW'(1);
                        o_unique_index <= r_ucnt[IW-1:0];
                        o_is_new       <= 1'b1;
                    end else begin
                        o_overflow <= 1'b1;
                    end
                    o_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                S_TRI: begin
                    case (r_step)
                        2'd0: begin
                            r_ra   <= corner_val;
                            r_step <= 2'd1;
                        end
                        2'd1: begin
                            r_rb   <= corner_val;
                            r_step <= 2'd2;
                        end
                        default: begin
                            o_out_a <= r_ra;
                            o_out_b <= r_rb;
                            o_out_c <= corner_val;
                            o_keep  <= (r_ra != r_rb) && (r_rb != corner_val)
                                       && (r_ra != corner_val);
                            o_done  <= 1'b1;
                            r_state <= S_IDLE;
                        end
                    endcase
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire
